FILE: rtl/core/assert_macros.svh
// Assertion macros used by the touch coordinate conditioner top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rst_n is high.
`define TCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define TCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/tcc_pkg.sv
// Package with types and constants of the touch coordinate conditioner.
package tcc_pkg;

    localparam int RAW_W        = 13;
    localparam int COORD_W      = 12;
    localparam int WORD_W       = 16;
    localparam int MODE_W       = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int SAMPLE_SHIFT = 3;
    localparam int STEP_W       = 4;
    localparam int MUL_STEPS    = COORD_W;
    localparam int DIV_STEPS    = RAW_W;
    localparam int WORK_W       = 2 * RAW_W;

    localparam logic [COORD_W-1:0] OUT_MIN_X_DEFAULT = 12'd0;
    localparam logic [COORD_W-1:0] OUT_MIN_Y_DEFAULT = 12'd0;

    localparam logic [RAW_W-1:0]   RAW_MIN_RESET = 13'd0;
    localparam logic [RAW_W-1:0]   RAW_MAX_RESET = 13'd4095;
    localparam logic [COORD_W-1:0] OUT_MAX_X_RESET = 12'd319;
    localparam logic [COORD_W-1:0] OUT_MAX_Y_RESET = 12'd239;

    localparam int MODE_MIRROR_X = 0;
    localparam int MODE_MIRROR_Y = 1;
    localparam int MODE_SWAP     = 2;
    localparam int MODE_PAIRS    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAW_MIN_X  = 3'd0,
        REG_RAW_MAX_X  = 3'd1,
        REG_RAW_MIN_Y  = 3'd2,
        REG_RAW_MAX_Y  = 3'd3,
        REG_OUT_MAX_X  = 3'd4,
        REG_OUT_MAX_Y  = 3'd5,
        REG_MODE_FLAGS = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_DIV  = 2'd2,
        ST_FIN  = 2'd3
    } state_t;

endpackage

FILE: rtl/core/touch_coordinate_conditioner.sv
// Top level: calibrates touch converter replies into screen coordinates.
// A word runs through the multiply, divide and final states into the output register.
// A new word is taken only when idle, after the bit-serial multiply (12 steps)
// and the bit-serial restoring divide (13 steps) that share one work register.
// The input is taken while a finished result still waits in the output register.
// Reset (rst_n low, asynchronous) restores the register defaults and clears pairing.
module touch_coordinate_conditioner
    import tcc_pkg::*;
#(
    parameter logic [COORD_W-1:0] OUT_MIN_X_VALUE = OUT_MIN_X_DEFAULT,
    parameter logic [COORD_W-1:0] OUT_MIN_Y_VALUE = OUT_MIN_Y_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAW_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 axis,
    input  logic [WORD_W-1:0]    reply_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 out_axis,
    output logic [COORD_W-1:0]   coordinate,
    output logic                 in_window
);

`include "assert_macros.svh"

    logic [RAW_W-1:0]   raw_min_x_reg, raw_max_x_reg, raw_min_y_reg, raw_max_y_reg;
    logic [COORD_W-1:0] out_max_x_reg, out_max_y_reg;
    logic [MODE_W-1:0]  mode_reg;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [WORK_W-1:0]  work_reg, work_next;
    logic [RAW_W-1:0]   a_reg, a_next;
    logic [RAW_W-1:0]   d_reg, d_next;
    logic               ch_reg, ch_next;
    logic               axis_reg, axis_next;
    logic               bad_reg, bad_next;

    logic               pair_second_reg, pair_second_next;
    logic [COORD_W-1:0] first_sample_reg, first_sample_next;
    logic               pair_axis_reg, pair_axis_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_axis_reg, out_axis_next;
    logic [COORD_W-1:0] coord_reg, coord_next;

    logic [RAW_W-1:0]   raw;
    logic               ch_in;
    logic [RAW_W-1:0]   rmin_in, rmax_in;
    logic [COORD_W-1:0] omax_in, omin_in;
    logic [RAW_W:0]     mul_sum;
    logic [RAW_W:0]     div_t;
    logic               div_ge;
    logic [RAW_W:0]     div_r;
    logic [COORD_W-1:0] omax_f, omin_f;
    logic               mirror_f;
    logic [RAW_W:0]     v_sum;
    logic [COORD_W-1:0] v_m;
    logic [COORD_W-1:0] c_val;
    logic               emit;
    logic               out_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_min_x_reg <= RAW_MIN_RESET;
            raw_max_x_reg <= RAW_MAX_RESET;
            raw_min_y_reg <= RAW_MIN_RESET;
            raw_max_y_reg <= RAW_MAX_RESET;
            out_max_x_reg <= OUT_MAX_X_RESET;
            out_max_y_reg <= OUT_MAX_Y_RESET;
            mode_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RAW_MIN_X:  raw_min_x_reg <= cfg_data;
                REG_RAW_MAX_X:  raw_max_x_reg <= cfg_data;
                REG_RAW_MIN_Y:  raw_min_y_reg <= cfg_data;
                REG_RAW_MAX_Y:  raw_max_y_reg <= cfg_data;
                REG_OUT_MAX_X:  out_max_x_reg <= cfg_data[COORD_W-1:0];
                REG_OUT_MAX_Y:  out_max_y_reg <= cfg_data[COORD_W-1:0];
                REG_MODE_FLAGS: mode_reg      <= cfg_data[MODE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            pair_second_reg  <= 1'b0;
            first_sample_reg <= '0;
            pair_axis_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            pair_second_reg  <= pair_second_next;
            first_sample_reg <= first_sample_next;
            pair_axis_reg    <= pair_axis_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        a_reg        <= a_next;
        d_reg        <= d_next;
        ch_reg       <= ch_next;
        axis_reg     <= axis_next;
        bad_reg      <= bad_next;
        out_axis_reg <= out_axis_next;
        coord_reg    <= coord_next;
    end

    // Channel selection for a new word.
    assign raw     = reply_word[WORD_W-1:SAMPLE_SHIFT];
    assign ch_in   = axis ^ mode_reg[MODE_SWAP];
    assign rmin_in = ch_in ? raw_min_y_reg : raw_min_x_reg;
    assign rmax_in = ch_in ? raw_max_y_reg : raw_max_x_reg;
    assign omax_in = ch_in ? out_max_y_reg : out_max_x_reg;
    assign omin_in = ch_in ? OUT_MIN_Y_VALUE : OUT_MIN_X_VALUE;

    // One shift-add step and one restoring divide step.
    assign mul_sum = {1'b0, work_reg[WORK_W-2:COORD_W]}
                   + (work_reg[0] ? {1'b0, a_reg} : '0);
    assign div_t   = {work_reg[WORK_W-1:RAW_W], work_reg[RAW_W-1]};
    assign div_ge  = div_t >= {1'b0, d_reg};
    assign div_r   = div_ge ? div_t - {1'b0, d_reg} : div_t;

    // Final mapping, mirror and window for the finished quotient.
    assign omax_f   = ch_reg ? out_max_y_reg : out_max_x_reg;
    assign omin_f   = ch_reg ? OUT_MIN_Y_VALUE : OUT_MIN_X_VALUE;
    assign mirror_f = ch_reg ? mode_reg[MODE_MIRROR_Y] : mode_reg[MODE_MIRROR_X];
    assign v_sum    = {1'b0, work_reg[RAW_W-1:0]} + {2'b00, omin_f};
    assign v_m      = mirror_f ? omax_f - v_sum[COORD_W-1:0] : v_sum[COORD_W-1:0];

    always_comb
    begin
        if (bad_reg || (v_sum > {2'b00, omax_f}) || (v_m <= omin_f) || (v_m >= omax_f))
            c_val = '0;
        else
            c_val = v_m;
    end

    assign emit = !mode_reg[MODE_PAIRS]
               || (pair_second_reg && (pair_axis_reg == axis_reg)
                   && (first_sample_reg == c_val));
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        work_next         = work_reg;
        a_next            = a_reg;
        d_next            = d_reg;
        ch_next           = ch_reg;
        axis_next         = axis_reg;
        bad_next          = bad_reg;
        pair_second_next  = pair_second_reg;
        first_sample_next = first_sample_reg;
        pair_axis_next    = pair_axis_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_axis_next     = out_axis_reg;
        coord_next        = coord_reg;
        in_stall          = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    a_next     = raw - rmin_in;
                    d_next     = rmax_in - rmin_in;
                    work_next  = {{(WORK_W-COORD_W){1'b0}}, omax_in - omin_in};
                    ch_next    = ch_in;
                    axis_next  = axis;
                    bad_next   = (rmax_in <= rmin_in) || (raw < rmin_in)
                              || (omax_in <= omin_in);
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                work_next = {1'b0, mul_sum, work_reg[COORD_W-1:1]};
                if (cnt_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DIV:
            begin
                // A quotient of 2^13 or more lies beyond any window.
                if ((cnt_reg == '0) && (work_reg[WORK_W-1:RAW_W] >= d_reg))
                    bad_next = 1'b1;
                work_next = {div_r[RAW_W-1:0], work_reg[RAW_W-2:0], div_ge};
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_FIN:
            begin
                if (!emit || out_free)
                begin
                    state_next = ST_IDLE;
                    if (mode_reg[MODE_PAIRS]
                        && (!pair_second_reg || (pair_axis_reg != axis_reg)))
                    begin
                        pair_second_next  = 1'b1;
                        first_sample_next = c_val;
                        pair_axis_next    = axis_reg;
                    end
                    else
                        pair_second_next = 1'b0;
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        out_axis_next  = axis_reg;
                        coord_next     = c_val;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_axis   = out_axis_reg;
    assign coordinate = coord_reg;
    assign in_window  = coord_reg != '0;

    `TCC_ASSERT(a_accept_starts_mul, (in_valid && !in_stall) |=> (state_reg == ST_MUL), "accepted word did not start the multiply")
    `TCC_ASSERT(a_word_from_fin, ($rose(out_valid) |-> $past(state_reg == ST_FIN)), "result word appeared outside the final step")
    `TCC_ASSERT(a_pair_emit, ((state_reg == ST_FIN) && mode_reg[MODE_PAIRS] && emit) |-> pair_second_reg, "paired result without a first sample")
    `TCC_ASSERT_ALWAYS(a_stall_while_busy, (state_reg != ST_IDLE) |-> in_stall, "input taken while a word is in work")

endmodule

FILE: tb/sv/touch_coordinate_conditioner_test.sv
// Self-checking testbench for the touch coordinate conditioner with a built-in predictor.
module touch_coordinate_conditioner_test
    import tcc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int RESET_CYCLES     = 10;
    localparam int DRAIN_CYCLES     = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PHASES    = 12;
    localparam int WORDS_PER_PHASE  = 125;
    localparam int PRESSURE_PHASE   = 6;

    typedef struct packed {
        logic              axis;
        logic [WORD_W-1:0] reply_word;
    } reply_t;

    typedef struct packed {
        logic               axis;
        logic [COORD_W-1:0] coordinate;
        logic               in_window;
    } coord_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RAW_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               axis = 1'b0;
    logic [WORD_W-1:0]  reply_word = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               out_axis;
    logic [COORD_W-1:0] coordinate;
    logic               in_window;

    logic [RAW_W-1:0]   cal_raw_min [2] = '{RAW_MIN_RESET, RAW_MIN_RESET};
    logic [RAW_W-1:0]   cal_raw_max [2] = '{RAW_MAX_RESET, RAW_MAX_RESET};
    logic [COORD_W-1:0] cal_out_max [2] = '{OUT_MAX_X_RESET, OUT_MAX_Y_RESET};
    logic [MODE_W-1:0]  cal_mode = '0;

    logic               pair_waiting = 1'b0;
    logic [COORD_W-1:0] pair_coord = '0;
    logic               pair_axis = 1'b0;

    reply_t        pending_words [$];
    coord_result_t coord_expected [$];
    logic          word_offered = 1'b0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;
    int unsigned   send_idle_by_mode [4] = '{0, 86, 0, 31};
    int unsigned   recv_stall_by_mode [4] = '{0, 0, 86, 31};
    logic          long_hold = 1'b0;
    event          long_hold_go;
    int            quiet_cycles = 0;
    int            mismatch_count = 0;

    touch_coordinate_conditioner dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .axis       (axis),
        .reply_word (reply_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_axis   (out_axis),
        .coordinate (coordinate),
        .in_window  (in_window)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
        mismatch_count++;
    endtask

    function automatic logic [COORD_W-1:0] map_sample(logic ch, logic [WORD_W-1:0] word);
        int unsigned raw, lo, hi, top, bottom, v;
        raw = 32'(word >> SAMPLE_SHIFT);
        lo = 32'(cal_raw_min[ch]);
        hi = 32'(cal_raw_max[ch]);
        top = 32'(cal_out_max[ch]);
        bottom = 32'(ch ? OUT_MIN_Y_DEFAULT : OUT_MIN_X_DEFAULT);
        if (hi <= lo || raw < lo || top <= bottom)
            return '0;
        v = (raw - lo) * (top - bottom) / (hi - lo) + bottom;
        if (v > top)
            return '0;
        if (cal_mode[ch ? MODE_MIRROR_Y : MODE_MIRROR_X])
            v = top - v;
        if (v > bottom && v < top)
            return v[COORD_W-1:0];
        return '0;
    endfunction

    task automatic predict_coordinate(logic ax, logic [WORD_W-1:0] word);
        logic [COORD_W-1:0] c;
        c = map_sample(ax ^ cal_mode[MODE_SWAP], word);
        if (cal_mode[MODE_PAIRS])
        begin
            if (!pair_waiting || pair_axis != ax)
            begin
                pair_waiting = 1'b1;
                pair_coord = c;
                pair_axis = ax;
                return;
            end
            pair_waiting = 1'b0;
            if (pair_coord != c)
                return;
        end
        else
            pair_waiting = 1'b0;
        coord_expected.push_back('{axis: ax, coordinate: c, in_window: (c != '0)});
    endtask

    always @(posedge clk)
    begin : word_driver
        reply_t next_word;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_coordinate(axis, reply_word);
                word_offered = 1'b0;
            end
            if (!word_offered)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    axis <= next_word.axis;
                    reply_word <= next_word.reply_word;
                    word_offered = 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : coord_monitor
        coord_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (coord_expected.size() == 0)
                    report_mismatch("unexpected word, coordinate", coordinate, 0);
                else
                begin
                    want = coord_expected.pop_front();
                    if (out_axis !== want.axis)
                        report_mismatch("out_axis", out_axis, want.axis);
                    if (coordinate !== want.coordinate)
                        report_mismatch("coordinate", coordinate, want.coordinate);
                    if (in_window !== want.in_window)
                        report_mismatch("in_window", in_window, want.in_window);
                end
            end
            out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
        end
    end

    always
    begin
        @(long_hold_go);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RAW_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_RAW_MIN_X:  cal_raw_min[0] = data;
            REG_RAW_MAX_X:  cal_raw_max[0] = data;
            REG_RAW_MIN_Y:  cal_raw_min[1] = data;
            REG_RAW_MAX_Y:  cal_raw_max[1] = data;
            REG_OUT_MAX_X:  cal_out_max[0] = data[COORD_W-1:0];
            REG_OUT_MAX_Y:  cal_out_max[1] = data[COORD_W-1:0];
            REG_MODE_FLAGS: cal_mode = data[MODE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_word(logic ax, logic [WORD_W-1:0] word);
        pending_words.push_back('{axis: ax, reply_word: word});
    endtask

    task automatic drain_block();
        while (pending_words.size() != 0 || word_offered || coord_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic reply_t make_reply(logic ax);
        reply_t r;
        int unsigned lo, hi;
        logic ch;
        ch = ax ^ cal_mode[MODE_SWAP];
        r.axis = ax;
        if ($urandom_range(99) < 35)
            r.reply_word = WORD_W'($urandom_range(16'hFFFF));
        else
        begin
            lo = (cal_raw_min[ch] > 16) ? cal_raw_min[ch] - 16 : 0;
            hi = (cal_raw_max[ch] < 8175) ? cal_raw_max[ch] + 16 : 8191;
            r.reply_word = {RAW_W'($urandom_range(hi, lo)),
                            SAMPLE_SHIFT'($urandom_range(7))};
        end
        return r;
    endfunction

    task automatic queue_random_words(int count);
        reply_t first, second;
        int queued;
        queued = 0;
        while (queued < count)
        begin
            first = make_reply(1'($urandom_range(1)));
            if (cal_mode[MODE_PAIRS] && $urandom_range(99) < 80)
            begin
                second = first;
                second.reply_word[SAMPLE_SHIFT-1:0] = SAMPLE_SHIFT'($urandom_range(7));
                if ($urandom_range(99) < 15)
                    second = make_reply(1'($urandom_range(1)));
                pending_words.push_back(first);
                pending_words.push_back(second);
                queued += 2;
            end
            else
            begin
                pending_words.push_back(first);
                queued++;
            end
        end
    endtask

    task automatic randomize_calibration();
        logic [RAW_W-1:0] lo, hi, span;
        for (int ch = 0; ch < 2; ch++)
        begin
            lo = RAW_W'($urandom_range(3000));
            hi = lo + RAW_W'($urandom_range(5000, 1));
            case ($urandom_range(9))
                0:
                begin
                    lo = '0;
                    hi = '1;
                end
                1: hi = RAW_W'($urandom_range(lo));
                2:
                begin
                    lo = '1;
                    hi = RAW_W'($urandom_range(8191));
                end
                default: ;
            endcase
            case ($urandom_range(9))
                0: span = '0;
                1: span = 13'd4095;
                default: span = RAW_W'($urandom_range(8191));
            endcase
            write_reg(ch ? REG_RAW_MIN_Y : REG_RAW_MIN_X, lo);
            write_reg(ch ? REG_RAW_MAX_Y : REG_RAW_MAX_X, hi);
            write_reg(ch ? REG_OUT_MAX_Y : REG_OUT_MAX_X, span);
        end
        write_reg(REG_MODE_FLAGS, RAW_W'($urandom_range(8191)));
    endtask

    initial
    begin : sequencer
        int unsigned idle_mode;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        push_word(1'b0, 16'h0000);
        push_word(1'b1, 16'hFFFF);
        push_word(1'b0, 16'(4095 << SAMPLE_SHIFT));
        push_word(1'b0, 16'((2048 << SAMPLE_SHIFT) | 7));
        push_word(1'b1, 16'(1 << SAMPLE_SHIFT));
        push_word(1'b1, 16'(4096 << SAMPLE_SHIFT));
        drain_block();

        write_reg(REG_RAW_MIN_X, RAW_W'(1000));
        write_reg(REG_RAW_MAX_X, RAW_W'(3000));
        write_reg(REG_OUT_MAX_X, RAW_W'(4095));
        write_reg(REG_RAW_MIN_Y, RAW_W'(200));
        write_reg(REG_RAW_MAX_Y, RAW_W'(200));
        write_reg(REG_OUT_MAX_Y, RAW_W'(0));
        write_reg(REG_MODE_FLAGS, RAW_W'(1 << MODE_MIRROR_X));
        write_reg(REG_SPARE, '1);
        push_word(1'b0, 16'(999 << SAMPLE_SHIFT));
        push_word(1'b0, 16'(1000 << SAMPLE_SHIFT));
        push_word(1'b0, 16'(2000 << SAMPLE_SHIFT));
        push_word(1'b0, 16'(3000 << SAMPLE_SHIFT));
        push_word(1'b1, 16'hFFFF);
        push_word(1'b1, 16'(200 << SAMPLE_SHIFT));
        drain_block();

        write_reg(REG_RAW_MIN_X, RAW_W'(0));
        write_reg(REG_RAW_MAX_X, RAW_W'(8191));
        write_reg(REG_OUT_MAX_X, RAW_W'(0));
        write_reg(REG_RAW_MAX_Y, RAW_W'(8191));
        write_reg(REG_RAW_MIN_Y, RAW_W'(0));
        write_reg(REG_OUT_MAX_Y, RAW_W'(4095));
        write_reg(REG_MODE_FLAGS, RAW_W'((1 << MODE_SWAP) | (1 << MODE_MIRROR_Y)));
        push_word(1'b0, 16'hFFF8);
        push_word(1'b0, 16'h8000);
        push_word(1'b1, 16'h8000);
        push_word(1'b0, 16'h0000);
        drain_block();

        write_reg(REG_RAW_MAX_X, RAW_W'(4095));
        write_reg(REG_OUT_MAX_X, RAW_W'(319));
        write_reg(REG_MODE_FLAGS, RAW_W'(1 << MODE_PAIRS));
        push_word(1'b0, 16'h4000);
        push_word(1'b0, 16'h4005);
        push_word(1'b0, 16'h4000);
        push_word(1'b0, 16'h6000);
        push_word(1'b0, 16'h4000);
        push_word(1'b1, 16'h4000);
        push_word(1'b1, 16'h4000);
        push_word(1'b1, 16'h0000);
        push_word(1'b1, 16'h0007);
        drain_block();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            randomize_calibration();
            idle_mode = p % 4;
            send_idle_pct = send_idle_by_mode[idle_mode];
            recv_stall_pct = recv_stall_by_mode[idle_mode];
            if (p == PRESSURE_PHASE)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                -> long_hold_go;
            end
            queue_random_words(WORDS_PER_PHASE);
            drain_block();
        end

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/tcc_pkg.sv
rtl/core/touch_coordinate_conditioner.sv
tb/sv/touch_coordinate_conditioner_test.sv
